FILE: rtl/cdl_pkg.sv
package cdl_pkg;

  localparam int CFG_W    = 7;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int COORD_W  = 6;
  localparam int IN_VAL_W = 16;
  localparam int TYPE_W   = 8;
  localparam int INDEX_W  = 4;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic {
    MODE_INSERT,
    MODE_READ
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_MERGED       = 3'd0,
    ST_APPENDED     = 3'd1,
    ST_FULL         = 3'd2,
    ST_READ_OK      = 3'd3,
    ST_OUT_OF_RANGE = 3'd4
  } status_t;

  typedef enum logic {
    REG_SLOT_COLUMNS,
    REG_SLOT_ROWS
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CNT,
    S_CNTW,
    S_SCAN,
    S_RDW,
    S_DONE
  } state_t;

endpackage

FILE: rtl/cdl_count_store.sv
module cdl_count_store #(
  parameter int NUM_SLOTS = 4096,
  parameter int SLOT_W    = 12,
  parameter int CNT_W     = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [CNT_W-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  logic [CNT_W-1:0]  wr_data,
  output logic              busy
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  logic [CNT_W-1:0]  mem [NUM_SLOTS];
  logic [CNT_W-1:0]  rd_data_r;
  logic [SLOT_W-1:0] clr_idx_r;
  logic              clr_busy_r;

  // zero sweep over every slot count after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + SLOT_W'(1);
      if (clr_idx_r == LAST_SLOT) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule

FILE: rtl/column_slot_depth_list_insert.sv
// Column slot depth list: one short list of (type, depth, normal) entries per
// (x,y) slot. Input words on in_* (valid/ready) either insert a pixel entry
// (merge into the entry with equal depth, else append, else drop when full)
// or read one entry of a slot. Each input word yields one result word on
// out_* (valid/ready). Slot geometry is set through the APB port (register 0
// slot_columns at 0x0, register 1 slot_rows at 0x4); write it only while idle.
// Items are handled one at a time through a slot-count memory and an entry
// memory, both with registered reads. An accepted word reads its slot count
// (a slot out of range goes straight to its result); a read then fetches
// the indexed entry, or reports out of range when the index is past the
// count; an insert scans the slot's entries for an equal depth, reading one
// stored entry per cycle from the entry memory port, and merges at the first
// match, else appends or drops when full. The next word can be accepted in
// the cycle after the result moves to the output register.
// After reset the counts memory is swept to zero, one slot per cycle, while
// in_ready stays low; APB writes are still taken. When the receiver stalls,
// the result holds in the output register; the next word is still accepted
// and processed, and its result waits until the output register frees.
module column_slot_depth_list_insert #(
  parameter int MAX_COLUMNS      = 64,
  parameter int MAX_ROWS         = 64,
  parameter int ENTRIES_PER_SLOT = 16,
  parameter int VALUE_BITS       = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_mode,
  input  logic [cdl_pkg::COORD_W-1:0]        in_slot_x,
  input  logic [cdl_pkg::COORD_W-1:0]        in_slot_y,
  input  logic signed [cdl_pkg::IN_VAL_W-1:0] in_depth_z,
  input  logic signed [cdl_pkg::IN_VAL_W-1:0] in_normal_value,
  input  logic [cdl_pkg::TYPE_W-1:0]         in_type_mask,
  input  logic [cdl_pkg::INDEX_W-1:0]        in_read_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cdl_pkg::STATUS_W-1:0]       out_status,
  output logic [cdl_pkg::POS_W-1:0]          out_entry_position,
  output logic [cdl_pkg::COUNT_W-1:0]        out_entry_count,
  output logic [cdl_pkg::TYPE_W-1:0]         out_entry_type,
  output logic signed [cdl_pkg::IN_VAL_W-1:0] out_entry_depth,
  output logic signed [cdl_pkg::IN_VAL_W-1:0] out_entry_normal,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cdl_pkg::PADDR_W-1:0]        paddr,
  input  logic [cdl_pkg::PDATA_W-1:0]        pwdata,
  output logic [cdl_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int CW      = cdl_pkg::CFG_W;
  localparam int TW      = cdl_pkg::TYPE_W;
  localparam int VB      = VALUE_BITS;
  localparam int PW      = cdl_pkg::POS_W;
  localparam int OCW     = cdl_pkg::COUNT_W;
  localparam int IVW     = cdl_pkg::IN_VAL_W;
  localparam int DW      = cdl_pkg::PDATA_W;
  localparam int PROD_W  = cdl_pkg::COORD_W + CW + 1;
  localparam int NUM_SLOTS   = MAX_COLUMNS * MAX_ROWS;
  localparam int NUM_ENTRIES = NUM_SLOTS * ENTRIES_PER_SLOT;
  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ADDR_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES_PER_SLOT + 1);
  localparam int EW      = TW + 2 * VB;
  localparam int CFG_MAX = (1 << CW) - 1;
  localparam int COL_LIM = (MAX_COLUMNS > CFG_MAX) ? CFG_MAX : MAX_COLUMNS;
  localparam int ROW_LIM = (MAX_ROWS > CFG_MAX) ? CFG_MAX : MAX_ROWS;
  localparam logic [CW-1:0] COL_CAP = CW'(COL_LIM);
  localparam logic [CW-1:0] ROW_CAP = CW'(ROW_LIM);

  // configuration
  logic [CW-1:0] cols_r, rows_r;
  logic [CW-1:0] cols_eff, rows_eff;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= cdl_pkg::CFG_RESET;
      rows_r <= cdl_pkg::CFG_RESET;
    end else if (cfg_wr) begin
      unique case (cdl_pkg::reg_idx_t'(paddr[2]))
        cdl_pkg::REG_SLOT_COLUMNS: cols_r <= pwdata[CW-1:0];
        cdl_pkg::REG_SLOT_ROWS:    rows_r <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cdl_pkg::reg_idx_t'(paddr[2]))
      cdl_pkg::REG_SLOT_COLUMNS: prdata = DW'(cols_r);
      cdl_pkg::REG_SLOT_ROWS:    prdata = DW'(rows_r);
      default:                   prdata = '0;
    endcase
  end

  assign cols_eff = (cols_r > COL_CAP) ? COL_CAP : cols_r;
  assign rows_eff = (rows_r > ROW_CAP) ? ROW_CAP : rows_r;

  // input conditioning
  logic [31:0]       dz_ext, nz_ext;
  logic [PROD_W-1:0] slot_calc;
  logic              in_oor;

  assign dz_ext    = 32'(in_depth_z);
  assign nz_ext    = 32'(in_normal_value);
  assign slot_calc = PROD_W'(in_slot_x) * PROD_W'(rows_eff) + PROD_W'(in_slot_y);
  assign in_oor    = ({1'b0, in_slot_x} >= cols_eff) || ({1'b0, in_slot_y} >= rows_eff);

  // state
  cdl_pkg::state_t state_r, state_nxt;
  cdl_pkg::mode_t  mode_r, mode_nxt;
  logic [VB-1:0]     dz_r, dz_nxt, nz_r, nz_nxt;
  logic [TW-1:0]     tm_r, tm_nxt;
  logic [cdl_pkg::INDEX_W-1:0] ri_r, ri_nxt;
  logic              oor_r, oor_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, p_r, p_nxt, pend_p_r, pend_p_nxt;
  logic              pend_r, pend_nxt;

  cdl_pkg::status_t res_status_r, res_status_nxt;
  logic [PW-1:0]     res_pos_r, res_pos_nxt;
  logic [OCW-1:0]    res_count_r, res_count_nxt;
  logic [TW-1:0]     res_type_r, res_type_nxt;
  logic [VB-1:0]     res_depth_r, res_depth_nxt, res_normal_r, res_normal_nxt;

  logic              out_valid_r, out_valid_nxt;
  cdl_pkg::status_t  out_status_r, out_status_nxt;
  logic [PW-1:0]     out_pos_r, out_pos_nxt;
  logic [OCW-1:0]    out_count_r, out_count_nxt;
  logic [TW-1:0]     out_type_r, out_type_nxt;
  logic [IVW-1:0]    out_depth_r, out_depth_nxt, out_normal_r, out_normal_nxt;
  logic [31:0]       res_depth_ext, res_normal_ext;

  // memory ports
  logic              busy;
  logic              cnt_rd_en, cnt_wr_en;
  logic [CNT_W-1:0]  cnt_q, cnt_wr_data;
  logic              ent_rd_en, ent_wr_en;
  logic [ADDR_W-1:0] ent_rd_addr, ent_wr_addr;
  logic [EW-1:0]     ent_wr_data, ent_q;
  logic [EW-1:0]     ent_mem [NUM_ENTRIES];
  logic [TW-1:0]     q_type, merged_type;
  logic [VB-1:0]     q_depth, q_normal;
  logic              issue;

  cdl_count_store #(
    .NUM_SLOTS(NUM_SLOTS),
    .SLOT_W   (SLOT_W),
    .CNT_W    (CNT_W)
  ) u_count_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (cnt_rd_en),
    .rd_addr(slot_r),
    .rd_data(cnt_q),
    .wr_en  (cnt_wr_en),
    .wr_addr(slot_r),
    .wr_data(cnt_wr_data),
    .busy   (busy)
  );

  always_ff @(posedge clk) begin
    if (ent_wr_en) begin
      ent_mem[ent_wr_addr] <= ent_wr_data;
    end
    if (ent_rd_en) begin
      ent_q <= ent_mem[ent_rd_addr];
    end
  end

  assign q_type      = ent_q[EW-1 -: TW];
  assign q_depth     = ent_q[2*VB-1 -: VB];
  assign q_normal    = ent_q[VB-1:0];
  assign merged_type = q_type | tm_r;
  assign issue       = p_r < cnt_r;

  assign in_ready       = (state_r == cdl_pkg::S_IDLE) && !busy;
  assign res_depth_ext  = 32'(res_depth_r);
  assign res_normal_ext = 32'(res_normal_r);

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    dz_nxt         = dz_r;
    nz_nxt         = nz_r;
    tm_nxt         = tm_r;
    ri_nxt         = ri_r;
    oor_nxt        = oor_r;
    slot_nxt       = slot_r;
    base_nxt       = base_r;
    cnt_nxt        = cnt_r;
    p_nxt          = p_r;
    pend_nxt       = pend_r;
    pend_p_nxt     = pend_p_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    res_count_nxt  = res_count_r;
    res_type_nxt   = res_type_r;
    res_depth_nxt  = res_depth_r;
    res_normal_nxt = res_normal_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_count_nxt  = out_count_r;
    out_type_nxt   = out_type_r;
    out_depth_nxt  = out_depth_r;
    out_normal_nxt = out_normal_r;
    cnt_rd_en      = 1'b0;
    cnt_wr_en      = 1'b0;
    cnt_wr_data    = cnt_r + CNT_W'(1);
    ent_rd_en      = 1'b0;
    ent_rd_addr    = base_r + ADDR_W'(p_r);
    ent_wr_en      = 1'b0;
    ent_wr_addr    = base_r + ADDR_W'(cnt_r);
    ent_wr_data    = {tm_r, dz_r, nz_r};

    unique case (state_r)
      cdl_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          mode_nxt  = cdl_pkg::mode_t'(in_mode);
          dz_nxt    = dz_ext[VB-1:0];
          nz_nxt    = nz_ext[VB-1:0];
          tm_nxt    = in_type_mask;
          ri_nxt    = in_read_index;
          oor_nxt   = in_oor;
          slot_nxt  = SLOT_W'(slot_calc);
          state_nxt = cdl_pkg::S_CNT;
        end
      end
      cdl_pkg::S_CNT: begin
        if (oor_r) begin
          res_status_nxt = cdl_pkg::ST_OUT_OF_RANGE;
          res_pos_nxt    = '0;
          res_count_nxt  = '0;
          res_type_nxt   = '0;
          res_depth_nxt  = '0;
          res_normal_nxt = '0;
          state_nxt      = cdl_pkg::S_DONE;
        end else begin
          cnt_rd_en = 1'b1;
          base_nxt  = ADDR_W'(slot_r) * ADDR_W'(ENTRIES_PER_SLOT);
          state_nxt = cdl_pkg::S_CNTW;
        end
      end
      cdl_pkg::S_CNTW: begin
        cnt_nxt    = cnt_q;
        p_nxt      = '0;
        pend_nxt   = 1'b0;
        pend_p_nxt = '0;
        if (mode_r == cdl_pkg::MODE_READ) begin
          if (int'(ri_r) < int'(cnt_q) && int'(ri_r) < ENTRIES_PER_SLOT) begin
            ent_rd_en   = 1'b1;
            ent_rd_addr = base_r + ADDR_W'(ri_r);
            state_nxt   = cdl_pkg::S_RDW;
          end else begin
            res_status_nxt = cdl_pkg::ST_OUT_OF_RANGE;
            res_pos_nxt    = PW'(ri_r);
            res_count_nxt  = OCW'(cnt_q);
            res_type_nxt   = '0;
            res_depth_nxt  = '0;
            res_normal_nxt = '0;
            state_nxt      = cdl_pkg::S_DONE;
          end
        end else begin
          state_nxt = cdl_pkg::S_SCAN;
        end
      end
      cdl_pkg::S_SCAN: begin
        // one read issued and one stored depth compared per cycle
        if (pend_r && (q_depth == dz_r)) begin
          ent_wr_en      = 1'b1;
          ent_wr_addr    = base_r + ADDR_W'(pend_p_r);
          ent_wr_data    = {merged_type, dz_r, nz_r};
          res_status_nxt = cdl_pkg::ST_MERGED;
          res_pos_nxt    = PW'(pend_p_r);
          res_count_nxt  = OCW'(cnt_r);
          res_type_nxt   = merged_type;
          res_depth_nxt  = dz_r;
          res_normal_nxt = nz_r;
          pend_nxt       = 1'b0;
          state_nxt      = cdl_pkg::S_DONE;
        end else if (!issue && !pend_r) begin
          if (int'(cnt_r) >= ENTRIES_PER_SLOT) begin
            res_status_nxt = cdl_pkg::ST_FULL;
            res_pos_nxt    = '0;
            res_count_nxt  = OCW'(cnt_r);
            res_type_nxt   = '0;
            res_depth_nxt  = '0;
            res_normal_nxt = '0;
          end else begin
            ent_wr_en      = 1'b1;
            cnt_wr_en      = 1'b1;
            res_status_nxt = cdl_pkg::ST_APPENDED;
            res_pos_nxt    = PW'(cnt_r);
            res_count_nxt  = OCW'(cnt_wr_data);
            res_type_nxt   = tm_r;
            res_depth_nxt  = dz_r;
            res_normal_nxt = nz_r;
          end
          state_nxt = cdl_pkg::S_DONE;
        end else begin
          ent_rd_en  = issue;
          pend_nxt   = issue;
          pend_p_nxt = p_r;
          if (issue) begin
            p_nxt = p_r + CNT_W'(1);
          end
        end
      end
      cdl_pkg::S_RDW: begin
        res_status_nxt = cdl_pkg::ST_READ_OK;
        res_pos_nxt    = PW'(ri_r);
        res_count_nxt  = OCW'(cnt_r);
        res_type_nxt   = q_type;
        res_depth_nxt  = q_depth;
        res_normal_nxt = q_normal;
        state_nxt      = cdl_pkg::S_DONE;
      end
      cdl_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pos_nxt    = res_pos_r;
          out_count_nxt  = res_count_r;
          out_type_nxt   = res_type_r;
          out_depth_nxt  = res_depth_ext[IVW-1:0];
          out_normal_nxt = res_normal_ext[IVW-1:0];
          state_nxt      = cdl_pkg::S_IDLE;
        end
      end
      default: state_nxt = cdl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdl_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      p_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      p_r         <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    dz_r         <= dz_nxt;
    nz_r         <= nz_nxt;
    tm_r         <= tm_nxt;
    ri_r         <= ri_nxt;
    oor_r        <= oor_nxt;
    slot_r       <= slot_nxt;
    base_r       <= base_nxt;
    cnt_r        <= cnt_nxt;
    pend_p_r     <= pend_p_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_count_r  <= res_count_nxt;
    res_type_r   <= res_type_nxt;
    res_depth_r  <= res_depth_nxt;
    res_normal_r <= res_normal_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= out_count_nxt;
    out_type_r   <= out_type_nxt;
    out_depth_r  <= out_depth_nxt;
    out_normal_r <= out_normal_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_entry_position = out_pos_r;
  assign out_entry_count    = out_count_r;
  assign out_entry_type     = out_type_r;
  assign out_entry_depth    = out_depth_r;
  assign out_entry_normal   = out_normal_r;

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ready)
    else $error("word accepted during count clear");

  a_count_bump: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_wr_en |-> (cnt_wr_data == cnt_r + CNT_W'(1)) &&
                  (int'(cnt_wr_data) <= ENTRIES_PER_SLOT) && ent_wr_en)
    else $error("slot count write out of step with append");

  a_pending_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (pend_p_r < cnt_r) && (state_r == cdl_pkg::S_SCAN))
    else $error("scan compare beyond slot count");

  a_accept_starts_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == cdl_pkg::S_CNT)
    else $error("accepted word did not start count lookup");
`endif

endmodule

FILE: tb/sv/tb_column_slot_depth_list_insert.sv
`timescale 1ns / 1ps

module tb_column_slot_depth_list_insert;

  localparam int MAX_COLUMNS      = 64;
  localparam int MAX_ROWS         = 64;
  localparam int ENTRIES_PER_SLOT = 16;
  localparam int SLOT_TOTAL       = MAX_COLUMNS * MAX_ROWS;
  localparam int CFG_W            = cdl_pkg::CFG_W;
  localparam int PADDR_W          = cdl_pkg::PADDR_W;
  localparam int PDATA_W          = cdl_pkg::PDATA_W;
  localparam int COORD_W          = cdl_pkg::COORD_W;
  localparam int IN_VAL_W         = cdl_pkg::IN_VAL_W;
  localparam int TYPE_W           = cdl_pkg::TYPE_W;
  localparam int INDEX_W          = cdl_pkg::INDEX_W;
  localparam int POS_W            = cdl_pkg::POS_W;
  localparam int COUNT_W          = cdl_pkg::COUNT_W;
  localparam int STATUS_W         = cdl_pkg::STATUS_W;

  typedef struct {
    cdl_pkg::mode_t             mode;
    logic [COORD_W-1:0]         x;
    logic [COORD_W-1:0]         y;
    logic signed [IN_VAL_W-1:0] depth;
    logic signed [IN_VAL_W-1:0] normal;
    logic [TYPE_W-1:0]          tmask;
    logic [INDEX_W-1:0]         ridx;
  } pixel_word_t;

  typedef struct {
    cdl_pkg::status_t           status;
    logic [POS_W-1:0]           pos;
    logic [COUNT_W-1:0]         count;
    logic [TYPE_W-1:0]          etype;
    logic signed [IN_VAL_W-1:0] depth;
    logic signed [IN_VAL_W-1:0] normal;
  } slot_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_mode = 1'b0;
  logic [COORD_W-1:0]         in_slot_x = '0;
  logic [COORD_W-1:0]         in_slot_y = '0;
  logic signed [IN_VAL_W-1:0] in_depth_z = '0;
  logic signed [IN_VAL_W-1:0] in_normal_value = '0;
  logic [TYPE_W-1:0]          in_type_mask = '0;
  logic [INDEX_W-1:0]         in_read_index = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [STATUS_W-1:0]        out_status;
  logic [POS_W-1:0]           out_entry_position;
  logic [COUNT_W-1:0]         out_entry_count;
  logic [TYPE_W-1:0]          out_entry_type;
  logic signed [IN_VAL_W-1:0] out_entry_depth;
  logic signed [IN_VAL_W-1:0] out_entry_normal;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [PADDR_W-1:0]         paddr = '0;
  logic [PDATA_W-1:0]         pwdata = '0;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;

  column_slot_depth_list_insert dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_slot_x          (in_slot_x),
    .in_slot_y          (in_slot_y),
    .in_depth_z         (in_depth_z),
    .in_normal_value    (in_normal_value),
    .in_type_mask       (in_type_mask),
    .in_read_index      (in_read_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_entry_position (out_entry_position),
    .out_entry_count    (out_entry_count),
    .out_entry_type     (out_entry_type),
    .out_entry_depth    (out_entry_depth),
    .out_entry_normal   (out_entry_normal),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #1 clk = ~clk;

  // shadow of the slot lists and geometry registers
  logic [CFG_W-1:0]           cfg_columns = cdl_pkg::CFG_RESET;
  logic [CFG_W-1:0]           cfg_rows = cdl_pkg::CFG_RESET;
  logic [COUNT_W-1:0]         slot_count [SLOT_TOTAL];
  logic [TYPE_W-1:0]          type_store [SLOT_TOTAL*ENTRIES_PER_SLOT];
  logic signed [IN_VAL_W-1:0] depth_store [SLOT_TOTAL*ENTRIES_PER_SLOT];
  logic signed [IN_VAL_W-1:0] normal_store [SLOT_TOTAL*ENTRIES_PER_SLOT];

  pixel_word_t  pixel_words[$];
  slot_result_t due_entries[$];
  pixel_word_t  offered_word;
  int           words_issued = 0;
  int           words_accepted = 0;
  int           mismatches = 0;
  int           status_seen [5] = '{default: 0};
  bit           steady = 1'b0;
  bit           long_hold_req = 1'b0;
  bit           hold_done = 1'b0;
  int           hold_left = 0;

  function automatic int clamp_dim(logic [CFG_W-1:0] value, int limit);
    return (int'(value) > limit) ? limit : int'(value);
  endfunction

  function automatic slot_result_t predict_slot_access(pixel_word_t w);
    int cols, rows, slot, base, cnt;
    slot_result_t r;
    r.status = cdl_pkg::ST_OUT_OF_RANGE;
    r.pos    = '0;
    r.count  = '0;
    r.etype  = '0;
    r.depth  = '0;
    r.normal = '0;
    cols = clamp_dim(cfg_columns, MAX_COLUMNS);
    rows = clamp_dim(cfg_rows, MAX_ROWS);
    if (int'(w.x) >= cols || int'(w.y) >= rows)
      return r;
    slot = int'(w.x) * rows + int'(w.y);
    base = slot * ENTRIES_PER_SLOT;
    cnt  = int'(slot_count[slot]);
    r.count = COUNT_W'(cnt);
    if (w.mode == cdl_pkg::MODE_READ) begin
      r.pos = w.ridx;
      if (int'(w.ridx) < cnt) begin
        r.status = cdl_pkg::ST_READ_OK;
        r.etype  = type_store[base + w.ridx];
        r.depth  = depth_store[base + w.ridx];
        r.normal = normal_store[base + w.ridx];
      end
      return r;
    end
    for (int p = 0; p < cnt; p++) begin
      if (depth_store[base + p] == w.depth) begin
        type_store[base + p]   = type_store[base + p] | w.tmask;
        normal_store[base + p] = w.normal;
        r.status = cdl_pkg::ST_MERGED;
        r.pos    = POS_W'(p);
        r.etype  = type_store[base + p];
        r.depth  = w.depth;
        r.normal = w.normal;
        return r;
      end
    end
    if (cnt >= ENTRIES_PER_SLOT) begin
      r.status = cdl_pkg::ST_FULL;
      return r;
    end
    type_store[base + cnt]   = w.tmask;
    depth_store[base + cnt]  = w.depth;
    normal_store[base + cnt] = w.normal;
    slot_count[slot]         = COUNT_W'(cnt + 1);
    r.status = cdl_pkg::ST_APPENDED;
    r.pos    = POS_W'(cnt);
    r.count  = COUNT_W'(cnt + 1);
    r.etype  = w.tmask;
    r.depth  = w.depth;
    r.normal = w.normal;
    return r;
  endfunction

  task automatic check_field(string label, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
    end
  endtask

  // driver: one word offered at a time, predicted when it is taken
  always @(posedge clk) begin : drive_words
    bit taken;
    taken = in_valid && in_ready;
    if (rst_n) begin
      if (taken) begin
        due_entries.push_back(predict_slot_access(offered_word));
        words_accepted++;
      end
      if (!in_valid || taken) begin
        if (pixel_words.size() > 0 && (steady || $urandom_range(99) >= 8)) begin
          offered_word = pixel_words.pop_front();
          in_valid        <= 1'b1;
          in_mode         <= offered_word.mode;
          in_slot_x       <= offered_word.x;
          in_slot_y       <= offered_word.y;
          in_depth_z      <= offered_word.depth;
          in_normal_value <= offered_word.normal;
          in_type_mask    <= offered_word.tmask;
          in_read_index   <= offered_word.ridx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare against the oldest prediction, drive out_ready
  always @(posedge clk) begin : watch_results
    slot_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_entries.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing expected, status %0d",
                   $time, out_status);
        end else begin
          want = due_entries.pop_front();
          check_field("status", int'(want.status), int'(out_status));
          check_field("entry_position", int'(want.pos), int'(out_entry_position));
          check_field("entry_count", int'(want.count), int'(out_entry_count));
          check_field("entry_type", int'(want.etype), int'(out_entry_type));
          check_field("entry_depth", int'(want.depth), int'(out_entry_depth));
          check_field("entry_normal", int'(want.normal), int'(out_entry_normal));
          if (int'(out_status) < 5)
            status_seen[out_status]++;
        end
      end
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 8);
      end
    end
  end

  task automatic push_word(cdl_pkg::mode_t mode, int x, int y, int depth, int normal,
                           int tmask, int ridx);
    pixel_word_t w;
    w.mode   = mode;
    w.x      = COORD_W'(x);
    w.y      = COORD_W'(y);
    w.depth  = IN_VAL_W'(depth);
    w.normal = IN_VAL_W'(normal);
    w.tmask  = TYPE_W'(tmask);
    w.ridx   = INDEX_W'(ridx);
    pixel_words.push_back(w);
    words_issued++;
  endtask

  // mostly a few hot slots with a small depth pool so slots fill, merge and
  // overflow; the rest is fully random or spread over the whole grid
  task automatic push_random(int count);
    int cols, rows, kind, x, y, depth;
    cdl_pkg::mode_t mode;
    cols = clamp_dim(cfg_columns, MAX_COLUMNS);
    rows = clamp_dim(cfg_rows, MAX_ROWS);
    for (int i = 0; i < count; i++) begin
      kind  = $urandom_range(99);
      mode  = ($urandom_range(99) < 25) ? cdl_pkg::MODE_READ : cdl_pkg::MODE_INSERT;
      x     = $urandom_range(63);
      y     = $urandom_range(63);
      depth = $urandom_range(65535);
      if (kind < 80) begin
        if (cols > 0)
          x = $urandom_range((cols < 2 ? cols : 2) - 1);
        if (rows > 0)
          y = $urandom_range((rows < 3 ? rows : 3) - 1);
        depth = int'($urandom_range(19)) * 1531 - 14000;
      end else if (kind >= 92) begin
        if (cols > 0)
          x = $urandom_range(cols - 1);
        if (rows > 0)
          y = $urandom_range(rows - 1);
      end
      push_word(mode, x, y, depth, $urandom_range(65535), $urandom_range(255),
                $urandom_range(15));
    end
  endtask

  task automatic wait_drained();
    while (words_accepted != words_issued || due_entries.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(cdl_pkg::reg_idx_t idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      cdl_pkg::REG_SLOT_COLUMNS: cfg_columns = value;
      cdl_pkg::REG_SLOT_ROWS:    cfg_rows = value;
    endcase
  endtask

  task automatic run_phase(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows, int count);
    wait_drained();
    write_reg(cdl_pkg::REG_SLOT_COLUMNS, cols);
    write_reg(cdl_pkg::REG_SLOT_ROWS, rows);
    push_random(count);
  endtask

  initial begin
    foreach (slot_count[i])
      slot_count[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(cdl_pkg::REG_SLOT_COLUMNS, 7'd64);
    write_reg(cdl_pkg::REG_SLOT_ROWS, 7'd64);

    // read of an empty slot, then append and merge at the depth extremes
    push_word(cdl_pkg::MODE_READ, 0, 0, 0, 0, 0, 0);
    push_word(cdl_pkg::MODE_INSERT, 0, 0, -32768, 32767, 8'h01, 0);
    push_word(cdl_pkg::MODE_INSERT, 0, 0, -32768, -32768, 8'h80, 15);
    push_word(cdl_pkg::MODE_INSERT, 63, 63, 32767, 0, 8'hFF, 0);
    push_word(cdl_pkg::MODE_READ, 0, 0, 0, 0, 0, 0);
    push_word(cdl_pkg::MODE_READ, 0, 0, 0, 0, 0, 1);
    // fill one slot, overflow it, then merge into its last entry
    for (int d = 0; d < ENTRIES_PER_SLOT; d++)
      push_word(cdl_pkg::MODE_INSERT, 5, 9, d * 100, d, 1 << (d % 8), 0);
    push_word(cdl_pkg::MODE_INSERT, 5, 9, 7777, 1, 8'h0F, 0);
    push_word(cdl_pkg::MODE_INSERT, 5, 9, 1500, -1, 8'hF0, 0);
    push_word(cdl_pkg::MODE_READ, 5, 9, 0, 0, 0, 15);
    push_random(300);

    run_phase(7'd1, 7'd1, 100);
    // receiver holds off while the sender keeps offering
    long_hold_req = 1'b1;
    run_phase(7'd127, 7'd127, 300);
    run_phase(7'd0, 7'd5, 40);
    run_phase(7'd13, 7'd7, 200);
    wait_drained();
    steady = 1'b1;
    run_phase(7'd64, 7'd1, 150);
    wait_drained();
    steady = 1'b0;
    run_phase(7'd1, 7'd64, 150);
    run_phase(7'd65, 7'd3, 60);
    wait_drained();
    repeat (30) @(posedge clk);

    $display("checked %0d words: %0d merged, %0d appended, %0d dropped full,",
             words_accepted, status_seen[0], status_seen[1], status_seen[2]);
    $display("%0d reads, %0d out of range, over 8 slot geometries",
             status_seen[3], status_seen[4]);
    if (mismatches == 0 && due_entries.size() == 0) begin
      $display("column_slot_depth_list_insert test passed");
    end else begin
      $display("column_slot_depth_list_insert test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", due_entries.size());
    $display("column_slot_depth_list_insert test failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/cdl_pkg.sv
rtl/cdl_count_store.sv
rtl/column_slot_depth_list_insert.sv
tb/sv/tb_column_slot_depth_list_insert.sv
